// ----- sv/slab_size_class_allocator_defines.svh -----
// Assertion macros shared by the allocator's RTL files.
// No dependencies; each user includes this header by bare file name.
`ifndef SLAB_SIZE_CLASS_ALLOCATOR_DEFINES_SVH
`define SLAB_SIZE_CLASS_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SSCA_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("ssca: invariant violated");
`define SSCA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssca: implication violated");
`define SSCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssca: next-cycle check violated");
`else
`define SSCA_ASSERT_ALWAYS(label, clk, rst, expr)
`define SSCA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SSCA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/ssca_pkg.sv -----
// Shared constants, codes and controller/datapath interface types.
// No dependencies.
package ssca_pkg;

   localparam int NUM_SLABS   = 16;
   localparam int CHUNKS      = 128;
   localparam int NUM_CLASSES = 129;
   localparam int MAX_SMALL   = 1024;
   localparam int GRAIN       = 8;
   localparam int GRAIN_SHIFT = $clog2(GRAIN);

   localparam int SLAB_W     = $clog2(NUM_SLABS);
   localparam int LINK_W     = $clog2(NUM_SLABS + 1);
   localparam int CHUNK_W    = $clog2(CHUNKS);
   localparam int CNT_W      = $clog2(CHUNKS + 1);
   localparam int CLS_W      = 8;
   localparam int CLS_AW     = $clog2(NUM_CLASSES);
   localparam int SPAN_SHIFT = CHUNK_W + GRAIN_SHIFT + $clog2(NUM_CLASSES - 1);
   localparam int CN_AW      = SLAB_W + CHUNK_W;
   localparam int CN_DEPTH   = NUM_SLABS * CHUNKS;
   localparam int REM_W      = SPAN_SHIFT - GRAIN_SHIFT;
   localparam int STEP_W     = $clog2(CHUNK_W);

   localparam logic [LINK_W-1:0] NO_SLAB  = LINK_W'(NUM_SLABS);
   localparam logic [CNT_W-1:0]  NO_CHUNK = CNT_W'(CHUNKS);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_PASS    = 2'd1,
      ST_NO_SLAB = 2'd2,
      ST_NULL    = 2'd3
   } rsp_status_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_SPLIT,
      CMD_HIT,
      CMD_DIV,
      CMD_A_HEAD,
      CMD_A_TAKE,
      CMD_A_NEXT,
      CMD_A_COUNT,
      CMD_UNL_READ,
      CMD_UNL_WRITE,
      CMD_F_PUSH,
      CMD_PSH_HEAD,
      CMD_PSH_PREV,
      CMD_OUT
   } dp_cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_LOOK,
      S_A_HEAD,
      S_A_TAKE,
      S_A_NEXT,
      S_A_COUNT,
      S_F_SPLIT,
      S_F_HIT,
      S_F_DIV,
      S_F_PUSH,
      S_P_HEAD,
      S_P_PREV,
      S_U_READ,
      S_U_WRITE,
      S_RESP
   } state_type;

   typedef struct packed {
      dp_cmd_type     op;
      logic           set_status;
      rsp_status_type status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic oversize;
      logic null_addr;
      logic head_valid;
      logic free_found;
      logic hit;
      logic div_last;
      logic chunk_avail;
      logic cursor_avail;
      logic full;
      logic empty;
      logic listed;
      logic out_free;
   } dp_flags_type;

endpackage

// ----- sv/ssca_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ssca_ctrl.sv -----
// Sequencing state machine for allocate and free.
// Depends on ssca_pkg and the assertion macro header.
`include "slab_size_class_allocator_defines.svh"
module ssca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  ssca_pkg::dp_flags_type flags,
   output ssca_pkg::ctrl_cmd_type cmd
);
   import ssca_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd.op         = CMD_NONE;
      cmd.set_status = 1'b0;
      cmd.status     = ST_DONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = CMD_ACCEPT;
               state_in = (req_op == OP_FREE) ? S_F_SPLIT : S_A_LOOK;
            end
         end
         S_A_LOOK: begin
            // class head read is in flight
            if (flags.oversize) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_PASS;
               state_in       = S_RESP;
            end else begin
               state_in = S_A_HEAD;
            end
         end
         S_A_HEAD: begin
            cmd.op = CMD_A_HEAD;
            if (flags.head_valid || flags.free_found) begin
               state_in = S_A_TAKE;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NO_SLAB;
               state_in       = S_RESP;
            end
         end
         S_A_TAKE: begin
            cmd.op = CMD_A_TAKE;
            if (flags.chunk_avail) begin
               state_in = S_A_NEXT;
            end else if (flags.cursor_avail) begin
               state_in = S_A_COUNT;
            end else begin
               // exhausted slab: drop it from the list
               cmd.set_status = 1'b1;
               cmd.status     = ST_NO_SLAB;
               state_in       = S_U_READ;
            end
         end
         S_A_NEXT: begin
            cmd.op   = CMD_A_NEXT;
            state_in = S_A_COUNT;
         end
         S_A_COUNT: begin
            cmd.op   = CMD_A_COUNT;
            state_in = flags.full ? S_U_READ : S_RESP;
         end
         S_F_SPLIT: begin
            if (flags.null_addr) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NULL;
               state_in       = S_RESP;
            end else begin
               cmd.op   = CMD_SPLIT;
               state_in = S_F_HIT;
            end
         end
         S_F_HIT: begin
            cmd.op = CMD_HIT;
            if (flags.hit) begin
               state_in = S_F_DIV;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_PASS;
               state_in       = S_RESP;
            end
         end
         S_F_DIV: begin
            cmd.op = CMD_DIV;
            if (flags.div_last) begin
               state_in = S_F_PUSH;
            end
         end
         S_F_PUSH: begin
            cmd.op = CMD_F_PUSH;
            if (flags.empty) begin
               state_in = flags.listed ? S_U_READ : S_RESP;
            end else begin
               state_in = flags.listed ? S_RESP : S_P_HEAD;
            end
         end
         S_P_HEAD: begin
            cmd.op   = CMD_PSH_HEAD;
            state_in = S_P_PREV;
         end
         S_P_PREV: begin
            cmd.op   = CMD_PSH_PREV;
            state_in = S_RESP;
         end
         S_U_READ: begin
            cmd.op   = CMD_UNL_READ;
            state_in = S_U_WRITE;
         end
         S_U_WRITE: begin
            cmd.op   = CMD_UNL_WRITE;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (flags.out_free) begin
               cmd.op   = CMD_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `SSCA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != S_IDLE)
   `SSCA_ASSERT_IMPL(a_out_only_in_resp, clock, reset, cmd.op == CMD_OUT, state_ff == S_RESP)
   `SSCA_ASSERT_NEXT(a_resp_exits, clock, reset, cmd.op == CMD_OUT, state_ff == S_IDLE)

endmodule

// ----- sv/ssca_dp.sv -----
// Datapath: slab tables, class-head and chunk-link memories, divider, result.
// Depends on ssca_pkg, ssca_ram and the assertion macro header.
`include "slab_size_class_allocator_defines.svh"
module ssca_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  ssca_pkg::ctrl_cmd_type cmd,
   output ssca_pkg::dp_flags_type flags,
   input  logic [31:0]            req_size,
   input  logic [31:0]            req_free_addr,
   input  logic                   csr_write_en,
   input  logic [31:0]            csr_write_data,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_chunk_addr,
   output logic [1:0]             rsp_status,
   output logic                   rsp_slab_released
);
   import ssca_pkg::*;

   // control state
   logic [31:0]          pool_base_ff, pool_base_in;
   logic [NUM_SLABS-1:0] in_use_ff, in_use_in;
   logic [NUM_SLABS-1:0] listed_ff, listed_in;
   logic [NUM_CLASSES-1:0] cv_ff, cv_in;
   logic                 cv_q_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   // slab tables, undefined until written
   logic [CLS_W-1:0]  cls_arr_ff [NUM_SLABS];
   logic [CLS_W-1:0]  cls_arr_in [NUM_SLABS];
   logic [CNT_W-1:0]  used_ff    [NUM_SLABS];
   logic [CNT_W-1:0]  used_in    [NUM_SLABS];
   logic [CNT_W-1:0]  cursor_ff  [NUM_SLABS];
   logic [CNT_W-1:0]  cursor_in  [NUM_SLABS];
   logic [CNT_W-1:0]  chead_ff   [NUM_SLABS];
   logic [CNT_W-1:0]  chead_in   [NUM_SLABS];
   logic [LINK_W-1:0] next_ff    [NUM_SLABS];
   logic [LINK_W-1:0] next_in    [NUM_SLABS];
   logic [LINK_W-1:0] prev_ff    [NUM_SLABS];
   logic [LINK_W-1:0] prev_in    [NUM_SLABS];

   // working registers
   logic                 large_ff, large_in;
   logic [CLS_W-1:0]     cls_ff, cls_in;
   logic [31:0]          addr_ff, addr_in;
   logic [SLAB_W-1:0]    s_ff, s_in;
   logic [SPAN_SHIFT-1:0] off_ff, off_in;
   logic                 hi_ok_ff, hi_ok_in;
   logic [CLS_W-1:0]     div_ff, div_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [CHUNK_W-1:0]   q_ff, q_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [CHUNK_W-1:0]   c_ff, c_in;
   logic [LINK_W-1:0]    p_ff, p_in;
   logic [LINK_W-1:0]    n_ff, n_in;
   logic [31:0]          res_addr_ff, res_addr_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic                 res_rel_ff, res_rel_in;
   logic [31:0]          rsp_addr_ff, rsp_addr_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic                 rsp_rel_ff, rsp_rel_in;

   // memories
   logic              ch_we;
   logic [LINK_W-1:0] ch_wdata;
   logic [LINK_W-1:0] ch_rdata;
   logic              cn_we;
   logic [CN_AW-1:0]  cn_waddr;
   logic [CN_AW-1:0]  cn_raddr;
   logic [CNT_W-1:0]  cn_rdata;

   // decode helpers
   logic [31:0]           size_nz;
   logic [11:0]           size_sum;
   logic [CLS_W-1:0]      cls_c;
   logic                  large_c;
   logic [31:0]           diff;
   logic [CLS_W-1:0]      cls_rd;
   logic [CLS_W-1:0]      cls_of;
   logic [CLS_W-1:0]      size8;
   logic [CNT_W-1:0]      head_rd;
   logic [CNT_W-1:0]      used_rd;
   logic [CNT_W-1:0]      cursor_rd;
   logic [CNT_W-1:0]      used_inc;
   logic [CNT_W-1:0]      used_dec;
   logic [LINK_W-1:0]     class_head_q;
   logic [SLAB_W-1:0]     free_idx;
   logic [REM_W:0]        trial;
   logic [CHUNK_W+CLS_W-1:0] prod;
   logic [LINK_W-1:0]     p_clean;
   logic [LINK_W-1:0]     n_clean;

   ssca_ram #(.WIDTH(LINK_W), .DEPTH(NUM_CLASSES)) u_class_head (
      .clock   (clock),
      .wr_en   (ch_we),
      .wr_addr (cls_ff),
      .wr_data (ch_wdata),
      .rd_addr (cls_ff),
      .rd_data (ch_rdata)
   );

   ssca_ram #(.WIDTH(CNT_W), .DEPTH(CN_DEPTH)) u_chunk_next (
      .clock   (clock),
      .wr_en   (cn_we),
      .wr_addr (cn_waddr),
      .wr_data (head_rd),
      .rd_addr (cn_raddr),
      .rd_data (cn_rdata)
   );

   always_comb begin
      size_nz  = (req_size == 32'd0) ? 32'd1 : req_size;
      size_sum = {1'b0, size_nz[10:0]} + 12'(GRAIN - 1);
      cls_c    = (size_nz <= 32'(GRAIN)) ? '0 : size_sum[10:3];
      large_c  = (size_nz > 32'(MAX_SMALL)) || (cls_c >= CLS_W'(NUM_CLASSES));

      diff      = addr_ff - pool_base_ff;
      cls_rd    = cls_arr_ff[s_ff];
      cls_of    = (cls_rd < CLS_W'(NUM_CLASSES)) ? cls_rd : '0;
      size8     = (cls_of == '0) ? CLS_W'(1) : cls_of;
      head_rd   = chead_ff[s_ff];
      used_rd   = used_ff[s_ff];
      cursor_rd = cursor_ff[s_ff];
      used_inc  = (used_rd < NO_CHUNK) ? used_rd + CNT_W'(1) : used_rd;
      used_dec  = (used_rd != '0) ? used_rd - CNT_W'(1) : '0;
      class_head_q = cv_q_ff ? ch_rdata : NO_SLAB;
      trial     = (REM_W+1)'(div_ff) << step_ff;
      prod      = (CHUNK_W+CLS_W)'(c_ff) * (CHUNK_W+CLS_W)'(size8);
      p_clean   = (p_ff < NO_SLAB) ? p_ff : NO_SLAB;
      n_clean   = (n_ff < NO_SLAB) ? n_ff : NO_SLAB;

      // lowest free slot
      free_idx = '0;
      for (int i = NUM_SLABS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_idx = SLAB_W'(i);
         end
      end
   end

   assign cn_raddr = {s_ff, head_rd[CHUNK_W-1:0]};
   assign cn_waddr = {s_ff, q_ff};

   always_comb begin
      flags.oversize     = large_ff;
      flags.null_addr    = (addr_ff == 32'd0);
      flags.head_valid   = (class_head_q < NO_SLAB);
      flags.free_found   = ~&in_use_ff;
      flags.hit          = hi_ok_ff && in_use_ff[s_ff] &&
                           ({1'b0, off_ff[SPAN_SHIFT-1:SPAN_SHIFT-CHUNK_W]} < size8);
      flags.div_last     = (step_ff == '0);
      flags.chunk_avail  = (head_rd < NO_CHUNK);
      flags.cursor_avail = (cursor_rd < NO_CHUNK);
      flags.full         = (used_inc >= NO_CHUNK);
      flags.empty        = (used_dec == '0);
      flags.listed       = listed_ff[s_ff];
      flags.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      pool_base_in  = csr_write_en ? csr_write_data : pool_base_ff;
      in_use_in     = in_use_ff;
      listed_in     = listed_ff;
      cv_in         = cv_ff;
      cls_arr_in    = cls_arr_ff;
      used_in       = used_ff;
      cursor_in     = cursor_ff;
      chead_in      = chead_ff;
      next_in       = next_ff;
      prev_in       = prev_ff;
      large_in      = large_ff;
      cls_in        = cls_ff;
      addr_in       = addr_ff;
      s_in          = s_ff;
      off_in        = off_ff;
      hi_ok_in      = hi_ok_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      step_in       = step_ff;
      c_in          = c_ff;
      p_in          = p_ff;
      n_in          = n_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      res_rel_in    = res_rel_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rel_in    = rsp_rel_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ch_we         = 1'b0;
      ch_wdata      = NO_SLAB;
      cn_we         = 1'b0;

      case (cmd.op)
         CMD_ACCEPT: begin
            large_in      = large_c;
            cls_in        = cls_c;
            addr_in       = req_free_addr;
            res_addr_in   = '0;
            res_status_in = ST_DONE;
            res_rel_in    = 1'b0;
         end
         CMD_SPLIT: begin
            s_in     = diff[SPAN_SHIFT+SLAB_W-1:SPAN_SHIFT];
            off_in   = diff[SPAN_SHIFT-1:0];
            hi_ok_in = (diff[31:SPAN_SHIFT+SLAB_W] == '0);
         end
         CMD_HIT: begin
            cls_in  = cls_of;
            div_in  = size8;
            rem_in  = off_ff[SPAN_SHIFT-1:GRAIN_SHIFT];
            q_in    = '0;
            step_in = STEP_W'(CHUNK_W - 1);
         end
         CMD_DIV: begin
            // one restoring step, quotient bit step_ff
            if ({1'b0, rem_ff} >= trial) begin
               rem_in        = rem_ff - trial[REM_W-1:0];
               q_in[step_ff] = 1'b1;
            end
            step_in = step_ff - STEP_W'(1);
         end
         CMD_A_HEAD: begin
            if (class_head_q < NO_SLAB) begin
               s_in = class_head_q[SLAB_W-1:0];
            end else if (!(&in_use_ff)) begin
               // claim a slot and put it at the head of the empty list
               s_in                 = free_idx;
               in_use_in[free_idx]  = 1'b1;
               listed_in[free_idx]  = 1'b1;
               cls_arr_in[free_idx] = cls_ff;
               used_in[free_idx]    = '0;
               cursor_in[free_idx]  = '0;
               chead_in[free_idx]   = NO_CHUNK;
               prev_in[free_idx]    = NO_SLAB;
               next_in[free_idx]    = NO_SLAB;
               ch_we                = 1'b1;
               ch_wdata             = {1'b0, free_idx};
               cv_in[cls_ff]        = 1'b1;
            end
         end
         CMD_A_TAKE: begin
            if (head_rd < NO_CHUNK) begin
               c_in = head_rd[CHUNK_W-1:0];
            end else if (cursor_rd < NO_CHUNK) begin
               c_in            = cursor_rd[CHUNK_W-1:0];
               cursor_in[s_ff] = cursor_rd + CNT_W'(1);
            end
         end
         CMD_A_NEXT: begin
            chead_in[s_ff] = (cn_rdata < NO_CHUNK) ? cn_rdata : NO_CHUNK;
         end
         CMD_A_COUNT: begin
            used_in[s_ff] = used_inc;
            res_addr_in   = pool_base_ff + (32'(s_ff) << SPAN_SHIFT) +
                            (32'(prod) << GRAIN_SHIFT);
         end
         CMD_UNL_READ: begin
            p_in = prev_ff[s_ff];
            n_in = next_ff[s_ff];
         end
         CMD_UNL_WRITE: begin
            if (n_ff < NO_SLAB) begin
               prev_in[n_ff[SLAB_W-1:0]] = p_clean;
            end
            if (p_ff < NO_SLAB) begin
               next_in[p_ff[SLAB_W-1:0]] = n_clean;
            end
            if (class_head_q == {1'b0, s_ff}) begin
               ch_we         = 1'b1;
               ch_wdata      = n_clean;
               cv_in[cls_ff] = 1'b1;
            end
            listed_in[s_ff] = 1'b0;
            if (res_rel_ff) begin
               in_use_in[s_ff] = 1'b0;
            end
         end
         CMD_F_PUSH: begin
            cn_we          = 1'b1;
            chead_in[s_ff] = {1'b0, q_ff};
            used_in[s_ff]  = used_dec;
            if (used_dec == '0) begin
               res_rel_in = 1'b1;
               // a listed slab is released once it is off the list
               if (!listed_ff[s_ff]) begin
                  in_use_in[s_ff] = 1'b0;
               end
            end
         end
         CMD_PSH_HEAD: begin
            prev_in[s_ff]   = NO_SLAB;
            next_in[s_ff]   = (class_head_q < NO_SLAB) ? class_head_q : NO_SLAB;
            n_in            = (class_head_q < NO_SLAB) ? class_head_q : NO_SLAB;
            ch_we           = 1'b1;
            ch_wdata        = {1'b0, s_ff};
            cv_in[cls_ff]   = 1'b1;
            listed_in[s_ff] = 1'b1;
         end
         CMD_PSH_PREV: begin
            if (n_ff < NO_SLAB) begin
               prev_in[n_ff[SLAB_W-1:0]] = {1'b0, s_ff};
            end
         end
         CMD_OUT: begin
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = res_addr_ff;
            rsp_status_in = res_status_ff;
            rsp_rel_in    = res_rel_ff;
         end
         default: begin
         end
      endcase

      if (cmd.set_status) begin
         res_status_in = cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
         in_use_ff    <= '0;
         listed_ff    <= '0;
         cv_ff        <= '0;
         cv_q_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pool_base_ff <= pool_base_in;
         in_use_ff    <= in_use_in;
         listed_ff    <= listed_in;
         cv_ff        <= cv_in;
         cv_q_ff      <= cv_ff[cls_ff];
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_arr_ff    <= cls_arr_in;
      used_ff       <= used_in;
      cursor_ff     <= cursor_in;
      chead_ff      <= chead_in;
      next_ff       <= next_in;
      prev_ff       <= prev_in;
      large_ff      <= large_in;
      cls_ff        <= cls_in;
      addr_ff       <= addr_in;
      s_ff          <= s_in;
      off_ff        <= off_in;
      hi_ok_ff      <= hi_ok_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      q_ff          <= q_in;
      step_ff       <= step_in;
      c_ff          <= c_in;
      p_ff          <= p_in;
      n_ff          <= n_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      res_rel_ff    <= res_rel_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rel_ff    <= rsp_rel_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chunk_addr    = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slab_released = rsp_rel_ff;

   `SSCA_ASSERT_ALWAYS(a_listed_in_use, clock, reset, (listed_ff & ~in_use_ff) == '0)
   `SSCA_ASSERT_IMPL(a_head_link_range, clock, reset, ch_we, ch_wdata <= NO_SLAB)
   `SSCA_ASSERT_NEXT(a_out_loaded, clock, reset, cmd.op == CMD_OUT, rsp_valid_ff)

endmodule

// ----- sv/slab_size_class_allocator.sv -----
// Slab allocator with size classes of 8 bytes: an allocate returns a chunk
// address (pool_base + slot * 128 KiB + chunk * chunk size) and a free returns
// a chunk to its slab. One request is worked at a time; an allocate's path to
// its result beat runs through the class-head and chunk-link memory reads and
// the list updates, and a free that hits a slab runs through the 7-step
// restoring divider that turns the slab offset into a chunk index.
// A result beat waits in the output register, so the next request is taken
// while the previous result is still stalled. The pool base register may be
// written only while the block is idle.
module slab_size_class_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_size,
   input  logic [31:0] req_free_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_chunk_addr,
   output logic [1:0]  rsp_status,
   output logic        rsp_slab_released,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data
);
   import ssca_pkg::*;

   ctrl_cmd_type cmd;
   dp_flags_type flags;

   ssca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .flags     (flags),
      .cmd       (cmd)
   );

   ssca_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .flags             (flags),
      .req_size          (req_size),
      .req_free_addr     (req_free_addr),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_chunk_addr    (rsp_chunk_addr),
      .rsp_status        (rsp_status),
      .rsp_slab_released (rsp_slab_released)
   );

endmodule
